// ----- hdl/ctl_pkg.sv -----
// Package for the C token lexer: token codes, character classes and operator tables.
`default_nettype none
package ctl_pkg;

	localparam int KW_COUNT = 32;

	// Token codes
	localparam logic [6:0] K_IDENT      = 7'd32;
	localparam logic [6:0] K_NUMBER     = 7'd33;
	localparam logic [6:0] K_STRING     = 7'd34;
	localparam logic [6:0] K_ELLIPSIS   = 7'd68;
	localparam logic [6:0] K_END        = 7'd69;
	localparam logic [6:0] K_ERR_CHAR   = 7'd70;
	localparam logic [6:0] K_ERR_STRING = 7'd71;
	localparam logic [6:0] K_ERR_DOT    = 7'd72;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	// Keyword spellings, right-justified and zero padded, in token code order
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("sizeof"), 64'("case"), 64'("default"), 64'("if"),
		64'("else"), 64'("switch"), 64'("for"), 64'("while"),
		64'("do"), 64'("goto"), 64'("continue"), 64'("break"),
		64'("return"), 64'("void"), 64'("char"), 64'("short"),
		64'("int"), 64'("long"), 64'("float"), 64'("double"),
		64'("signed"), 64'("unsigned"), 64'("struct"), 64'("union"),
		64'("enum"), 64'("auto"), 64'("register"), 64'("static"),
		64'("extern"), 64'("typedef"), 64'("const"), 64'("volatile")
	};

	// Lexer modes, one-hot
	typedef enum logic [6:0] {
		M_IDLE   = 7'b0000001,
		M_IDENT  = 7'b0000010,
		M_NUMBER = 7'b0000100,
		M_STRING = 7'b0001000,
		M_OP     = 7'b0010000,
		M_DOT1   = 7'b0100000,
		M_DOT2   = 7'b1000000
	} lex_mode_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] code;
	} single_t;

	typedef struct packed {
		logic       hit;
		logic [6:0] code;
		logic [7:0] n1;
		logic [6:0] c1;
		logic [7:0] n2;
		logic [6:0] c2;
	} pair_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {["a":"z"]}) || (c inside {["A":"Z"]}) || (c == CH_UNDER);
	endfunction

	// Single-character punctuators
	function automatic single_t single_lookup(input logic [7:0] c);
		single_t r;
		r.hit = 1'b1;
		case (c)
			"(":     r.code = 7'd35;
			")":     r.code = 7'd36;
			"[":     r.code = 7'd37;
			"]":     r.code = 7'd38;
			"~":     r.code = 7'd39;
			"*":     r.code = 7'd40;
			"/":     r.code = 7'd41;
			"%":     r.code = 7'd42;
			"^":     r.code = 7'd53;
			"?":     r.code = 7'd58;
			":":     r.code = 7'd59;
			",":     r.code = 7'd64;
			"{":     r.code = 7'd65;
			"}":     r.code = 7'd66;
			";":     r.code = 7'd67;
			default: begin
				r.hit  = 1'b0;
				r.code = K_ERR_CHAR;
			end
		endcase
		return r;
	endfunction

	// Characters that may start a two-character operator
	function automatic pair_t pair_lookup(input logic [7:0] c);
		pair_t r;
		r = '{hit: 1'b1, code: 7'd0, n1: 8'd0, c1: 7'd0, n2: CH_NUL, c2: 7'd0};
		case (c)
			"+":     r = '{1'b1, 7'd43, "+", 7'd44, CH_NUL, 7'd0};
			"-":     r = '{1'b1, 7'd45, "-", 7'd46, CH_NUL, 7'd0};
			"<":     r = '{1'b1, 7'd47, "=", 7'd48, "<", 7'd49};
			">":     r = '{1'b1, 7'd50, "=", 7'd51, ">", 7'd52};
			"&":     r = '{1'b1, 7'd54, "&", 7'd55, CH_NUL, 7'd0};
			"|":     r = '{1'b1, 7'd56, "|", 7'd57, CH_NUL, 7'd0};
			"!":     r = '{1'b1, 7'd60, "=", 7'd61, CH_NUL, 7'd0};
			"=":     r = '{1'b1, 7'd62, "=", 7'd63, CH_NUL, 7'd0};
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/c_token_lexer_unit.sv -----
// Top level of the C token lexer: byte input channel, token result channel.
// Usage:
//   Source bytes enter on char_code/char_valid/char_ready, one per transfer.
//   Byte 0 ends a text: a token in progress is closed, an end token follows,
//   and the byte offset restarts at 0 for the next text.
//   Tokens leave on token_kind/start_offset/token_length/last_in_run with
//   token_valid/token_ready. last_in_run marks the final token of one byte.
// Output: the first token caused by a byte is presented the cycle after that
//   byte's transfer. One byte causes 0 to 3 tokens.
// Throughput: one byte per cycle while each byte yields at most one token and
//   the receiver takes it. A byte with more tokens holds the input until the
//   last of them leaves the three-entry result buffer, which drains one token a cycle while the receiver takes them.
// Reset: arst_n clears the lexer state and the result buffer; the first byte
//   after reset is at offset 0.
// Stall: while the receiver holds token_ready low, the current token holds and
//   char_ready drops once the buffer cannot be reloaded.
// Offsets saturate at 2^OFFSET_WIDTH-1; output fields clamp at 2^32-1.
`default_nettype none
module c_token_lexer_unit
	import ctl_pkg::*;
#(
	parameter int OFFSET_WIDTH = 32
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  char_code,
	input  wire logic        char_valid,
	output logic             char_ready,
	output logic      [6:0]  token_kind,
	output logic      [31:0] start_offset,
	output logic      [31:0] token_length,
	output logic             last_in_run,
	output logic             token_valid,
	input  wire logic        token_ready
);

	localparam int W = OFFSET_WIDTH;

	// Lexer state
	lex_mode_t      mode_q, mode_d;
	logic [7:0]     pend_q, pend_d;
	logic [W-1:0]   ts_q, ts_d;
	logic [W-1:0]   pos_q, pos_d;
	logic [63:0]    kb_q, kb_d;
	logic           tl_q, tl_d;

	// Result buffer
	logic [6:0]     kind_q  [3];
	logic [31:0]    start_q [3];
	logic [31:0]    len_q   [3];
	logic [1:0]     hd_q;
	logic [1:0]     cnt_q;

	// Results of the current byte
	logic [6:0]     r_kind  [3];
	logic [W-1:0]   r_start [3];
	logic [W-1:0]   r_len   [3];
	logic [1:0]     r_n;

	logic [6:0]     id_kind;
	logic [W-1:0]   pos_inc, ts_inc, dif, dif_m1;
	logic           done;
	pair_t          pp, pc;
	single_t        sc;
	logic           in_xfer, out_xfer;

	function automatic logic [31:0] clamp32(input logic [W-1:0] v);
		logic [63:0] e;
		e = 64'(v);
		return (e[63:32] != 32'd0) ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	ctl_kw_match u_kw (
		.chars    (kb_q),
		.too_long (tl_q),
		.kind     (id_kind)
	);

	assign in_xfer  = char_valid && char_ready;
	assign out_xfer = token_valid && token_ready;

	assign pos_inc = (pos_q == '1) ? pos_q : pos_q + W'(1);
	assign ts_inc  = (ts_q == '1) ? ts_q : ts_q + W'(1);
	assign dif     = (pos_q > ts_q) ? pos_q - ts_q : '0;
	assign dif_m1  = (dif != '0) ? dif - W'(1) : '0;
	assign pp      = pair_lookup(pend_q);
	assign pc      = pair_lookup(char_code);
	assign sc      = single_lookup(char_code);

	// Next state and results for one byte
	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		ts_d   = ts_q;
		kb_d   = kb_q;
		tl_d   = tl_q;
		pos_d  = pos_inc;
		done   = 1'b0;
		r_n    = 2'd0;
		for (int i = 0; i < 3; i++) begin
			r_kind[i]  = K_END;
			r_start[i] = '0;
			r_len[i]   = '0;
		end

		// Close or extend the token in progress
		case (mode_q)
			M_IDENT: begin
				if (is_alpha(char_code) || is_digit(char_code)) begin
					if (!tl_q && kb_q[63:56] != 8'd0) tl_d = 1'b1;
					else if (!tl_q) kb_d = {kb_q[55:0], char_code};
					done = 1'b1;
				end else begin
					r_kind[0] = id_kind; r_start[0] = ts_q; r_len[0] = dif;
					r_n = 2'd1;
					mode_d = M_IDLE;
				end
			end
			M_NUMBER: begin
				if (is_digit(char_code)) begin
					done = 1'b1;
				end else begin
					r_kind[0] = K_NUMBER; r_start[0] = ts_q; r_len[0] = dif;
					r_n = 2'd1;
					mode_d = M_IDLE;
				end
			end
			M_STRING: begin
				if (char_code == CH_QUOTE) begin
					r_kind[0] = K_STRING; r_start[0] = ts_inc; r_len[0] = dif_m1;
					r_n = 2'd1;
					mode_d = M_IDLE;
					done = 1'b1;
				end else if (char_code == CH_NUL) begin
					r_kind[0] = K_ERR_STRING; r_start[0] = ts_q; r_len[0] = dif;
					r_n = 2'd1;
					mode_d = M_IDLE;
				end else begin
					done = 1'b1;
				end
			end
			M_OP: begin
				if (pp.hit) begin
					r_start[0] = ts_q;
					r_n = 2'd1;
					if (char_code != CH_NUL && char_code == pp.n1) begin
						r_kind[0] = pp.c1; r_len[0] = W'(2); done = 1'b1;
					end else if (char_code != CH_NUL && char_code == pp.n2) begin
						r_kind[0] = pp.c2; r_len[0] = W'(2); done = 1'b1;
					end else begin
						r_kind[0] = pp.code; r_len[0] = W'(1);
					end
				end
				mode_d = M_IDLE;
			end
			M_DOT1: begin
				if (char_code == CH_DOT) begin
					mode_d = M_DOT2;
					done = 1'b1;
				end else begin
					r_kind[0] = K_ERR_DOT; r_start[0] = ts_q; r_len[0] = W'(1);
					r_n = 2'd1;
					mode_d = M_IDLE;
				end
			end
			M_DOT2: begin
				if (char_code == CH_DOT) begin
					r_kind[0] = K_ELLIPSIS; r_start[0] = ts_q; r_len[0] = W'(3);
					r_n = 2'd1;
					done = 1'b1;
				end else begin
					r_kind[0] = K_ERR_DOT; r_start[0] = ts_q;   r_len[0] = W'(2);
					r_kind[1] = K_ERR_DOT; r_start[1] = ts_inc; r_len[1] = W'(1);
					r_n = 2'd2;
				end
				mode_d = M_IDLE;
			end
			default: mode_d = M_IDLE;
		endcase

		// Lex the byte on its own
		if (!done) begin
			if (char_code == CH_NUL) begin
				r_kind[r_n] = K_END; r_start[r_n] = pos_q; r_len[r_n] = '0;
				r_n    = r_n + 2'd1;
				mode_d = M_IDLE;
				pend_d = 8'd0;
				ts_d   = '0;
				kb_d   = '0;
				tl_d   = 1'b0;
				pos_d  = '0;
			end else if (is_space(char_code)) begin
				mode_d = mode_d;
			end else if (is_alpha(char_code)) begin
				mode_d = M_IDENT;
				ts_d   = pos_q;
				kb_d   = {56'd0, char_code};
				tl_d   = 1'b0;
			end else if (is_digit(char_code)) begin
				mode_d = M_NUMBER;
				ts_d   = pos_q;
			end else if (char_code == CH_QUOTE) begin
				mode_d = M_STRING;
				ts_d   = pos_q;
			end else if (char_code == CH_DOT) begin
				mode_d = M_DOT1;
				ts_d   = pos_q;
			end else if (pc.hit) begin
				mode_d = M_OP;
				pend_d = char_code;
				ts_d   = pos_q;
			end else begin
				r_kind[r_n]  = sc.hit ? sc.code : K_ERR_CHAR;
				r_start[r_n] = pos_q;
				r_len[r_n]   = W'(1);
				r_n = r_n + 2'd1;
			end
		end
	end

	// Reload only when the buffer is empty or its last token leaves now
	assign char_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && token_ready);

	// Lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= 8'd0;
			ts_q   <= '0;
			pos_q  <= '0;
			kb_q   <= '0;
			tl_q   <= 1'b0;
		end else if (in_xfer) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			ts_q   <= ts_d;
			pos_q  <= pos_d;
			kb_q   <= kb_d;
			tl_q   <= tl_d;
		end
	end

	// Result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_q  <= 2'd0;
			cnt_q <= 2'd0;
		end else if (in_xfer) begin
			hd_q  <= 2'd0;
			cnt_q <= r_n;
		end else if (out_xfer) begin
			hd_q  <= hd_q + 2'd1;
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Result buffer payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int i = 0; i < 3; i++) begin
				kind_q[i]  <= r_kind[i];
				start_q[i] <= clamp32(r_start[i]);
				len_q[i]   <= clamp32(r_len[i]);
			end
		end
	end

	assign token_valid  = (cnt_q != 2'd0);
	assign token_kind   = kind_q[hd_q];
	assign start_offset = start_q[hd_q];
	assign token_length = len_q[hd_q];
	assign last_in_run  = (cnt_q == 2'd1);

	// Buffer never runs past its three entries
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd0) |-> ({1'b0, hd_q} + {1'b0, cnt_q} <= 3'd3))
		else $error("result buffer index out of range");

	// No reload while more than one token is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q > 2'd1) |-> !char_ready)
		else $error("input taken over pending tokens");

	// End of text restarts the offset and yields a final end token
	a_end_text: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && char_code == CH_NUL && !done) |=>
		(pos_q == '0 && token_valid && kind_q[cnt_q - 2'd1] == K_END))
		else $error("end of text not handled");

	// Buffer drains one token per transfer
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !in_xfer) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("result buffer count slip");

endmodule
`default_nettype wire

// ----- hdl/ctl_kw_match.sv -----
// Keyword matcher: maps the packed identifier characters to a keyword or identifier code.
`default_nettype none
module ctl_kw_match
	import ctl_pkg::*;
(
	input  wire logic [63:0] chars,
	input  wire logic        too_long,
	output logic      [6:0]  kind
);

	// Parallel compare against all keywords; spellings are unique so at most one hits
	always_comb begin
		kind = K_IDENT;
		if (!too_long) begin
			for (int k = 0; k < KW_COUNT; k++) begin
				if (chars == KW_TEXT[k]) kind = 7'(k);
			end
		end
	end

endmodule
`default_nettype wire

// ----- tb/c_token_lexer_checker.sv -----
// Checker for the C token lexer: watches both channels, predicts tokens and compares them.
`default_nettype none
module c_token_lexer_checker
	import ctl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  char_code,
	input  wire logic        char_valid,
	input  wire logic        char_ready,
	input  wire logic [6:0]  token_kind,
	input  wire logic [31:0] start_offset,
	input  wire logic [31:0] token_length,
	input  wire logic        last_in_run,
	input  wire logic        token_valid,
	input  wire logic        token_ready,
	output int               fail_count,
	output int               pending_tokens
);

	typedef struct {
		logic [6:0]  kind;
		logic [31:0] start;
		logic [31:0] len;
		logic        last;
	} token_t;

	typedef enum int {S_IDLE, S_IDENT, S_NUMBER, S_STRING, S_OP, S_DOT1, S_DOT2} lex_state_t;

	token_t      token_q[$];
	token_t      byte_tokens[$];
	lex_state_t  lex_st;
	logic [7:0]  op_char;
	logic [31:0] tok_start;
	logic [31:0] pos;
	logic [63:0] kw_buf;
	logic        kw_overflow;

	localparam logic [31:0] POS_TOP = 32'hFFFF_FFFF;

	function automatic logic [31:0] bump(input logic [31:0] a);
		return (a == POS_TOP) ? a : a + 32'd1;
	endfunction

	function automatic logic [31:0] span(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? a - b : 32'd0;
	endfunction

	// Keyword match on the packed identifier text
	function automatic logic [6:0] ident_code();
		if (kw_overflow)
			return K_IDENT;
		for (int k = 0; k < KW_COUNT; k++)
			if (KW_TEXT[k] == kw_buf)
				return 7'(k);
		return K_IDENT;
	endfunction

	task automatic push(input logic [6:0] kind, input logic [31:0] start,
		input logic [31:0] len);
		token_t t;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.last  = 1'b0;
		byte_tokens.push_back(t);
	endtask

	// Predict the tokens caused by one byte
	task automatic lex_byte(input logic [7:0] c);
		logic    consumed;
		pair_t   pr;
		single_t sg;
		consumed = 1'b0;
		byte_tokens.delete();
		case (lex_st)
			S_IDENT: begin
				if (is_alpha(c) || is_digit(c)) begin
					if (!kw_overflow && kw_buf[63:56] != 8'd0)
						kw_overflow = 1'b1;
					else if (!kw_overflow)
						kw_buf = {kw_buf[55:0], c};
					consumed = 1'b1;
				end else begin
					push(ident_code(), tok_start, span(pos, tok_start));
					lex_st = S_IDLE;
				end
			end
			S_NUMBER: begin
				if (is_digit(c))
					consumed = 1'b1;
				else begin
					push(K_NUMBER, tok_start, span(pos, tok_start));
					lex_st = S_IDLE;
				end
			end
			S_STRING: begin
				if (c == CH_QUOTE) begin
					push(K_STRING, bump(tok_start), span(span(pos, tok_start), 32'd1));
					lex_st = S_IDLE;
					consumed = 1'b1;
				end else if (c == CH_NUL) begin
					push(K_ERR_STRING, tok_start, span(pos, tok_start));
					lex_st = S_IDLE;
				end else
					consumed = 1'b1;
			end
			S_OP: begin
				pr = pair_lookup(op_char);
				if (c != CH_NUL && c == pr.n1) begin
					push(pr.c1, tok_start, 32'd2);
					consumed = 1'b1;
				end else if (c != CH_NUL && c == pr.n2) begin
					push(pr.c2, tok_start, 32'd2);
					consumed = 1'b1;
				end else
					push(pr.code, tok_start, 32'd1);
				lex_st = S_IDLE;
			end
			S_DOT1: begin
				if (c == CH_DOT) begin
					lex_st = S_DOT2;
					consumed = 1'b1;
				end else begin
					push(K_ERR_DOT, tok_start, 32'd1);
					lex_st = S_IDLE;
				end
			end
			S_DOT2: begin
				if (c == CH_DOT) begin
					push(K_ELLIPSIS, tok_start, 32'd3);
					consumed = 1'b1;
				end else begin
					push(K_ERR_DOT, tok_start, 32'd2);
					push(K_ERR_DOT, bump(tok_start), 32'd1);
				end
				lex_st = S_IDLE;
			end
			default: lex_st = S_IDLE;
		endcase

		if (!consumed) begin
			pr = pair_lookup(c);
			sg = single_lookup(c);
			if (c == CH_NUL) begin
				push(K_END, pos, 32'd0);
				lex_st = S_IDLE;
				op_char = 8'd0;
				tok_start = 32'd0;
				kw_buf = 64'd0;
				kw_overflow = 1'b0;
				pos = 32'hFFFF_FFFF;
			end else if (is_space(c)) begin
			end else if (is_alpha(c)) begin
				lex_st = S_IDENT;
				tok_start = pos;
				kw_buf = {56'd0, c};
				kw_overflow = 1'b0;
			end else if (is_digit(c)) begin
				lex_st = S_NUMBER;
				tok_start = pos;
			end else if (c == CH_QUOTE) begin
				lex_st = S_STRING;
				tok_start = pos;
			end else if (c == CH_DOT) begin
				lex_st = S_DOT1;
				tok_start = pos;
			end else if (pr.hit) begin
				lex_st = S_OP;
				op_char = c;
				tok_start = pos;
			end else if (sg.hit)
				push(sg.code, pos, 32'd1);
			else
				push(K_ERR_CHAR, pos, 32'd1);
		end
		// end of text wraps the offset back to 0
		pos = (c == CH_NUL) ? 32'd0 : bump(pos);

		foreach (byte_tokens[i]) begin
			byte_tokens[i].last = (i == byte_tokens.size() - 1);
			token_q.push_back(byte_tokens[i]);
		end
	endtask

	task automatic compare(input token_t e);
		if (token_kind !== e.kind) begin
			$error("token_kind expected %0d actual %0d", e.kind, token_kind);
			fail_count++;
		end
		if (start_offset !== e.start) begin
			$error("start_offset expected %0d actual %0d", e.start, start_offset);
			fail_count++;
		end
		if (token_length !== e.len) begin
			$error("token_length expected %0d actual %0d", e.len, token_length);
			fail_count++;
		end
		if (last_in_run !== e.last) begin
			$error("last_in_run expected %0d actual %0d", e.last, last_in_run);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		lex_st = S_IDLE;
		op_char = 8'd0;
		tok_start = 32'd0;
		pos = 32'd0;
		kw_buf = 64'd0;
		kw_overflow = 1'b0;
	end

	assign pending_tokens = token_q.size();

	// Monitor token transfers first, then byte transfers, on each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (token_valid && token_ready) begin
				if (token_q.size() == 0) begin
					$error("token transfer with none expected: kind %0d", token_kind);
					fail_count++;
				end else
					compare(token_q.pop_front());
			end
			if (char_valid && char_ready)
				lex_byte(char_code);
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_c_token_lexer_unit.sv -----
// Testbench top for the C token lexer: stimulus, receiver stalls and verdict.
`default_nettype none
module tb_c_token_lexer_unit;
	import ctl_pkg::*;

	logic        clk;
	logic        arst_n;
	logic [7:0]  char_code;
	logic        char_valid;
	logic        char_ready;
	logic [6:0]  token_kind;
	logic [31:0] start_offset;
	logic [31:0] token_length;
	logic        last_in_run;
	logic        token_valid;
	logic        token_ready;
	int          fail_count;
	int          pending_tokens;
	logic        stim_done;

	c_token_lexer_unit i_dut (
		.clk(clk), .arst_n(arst_n), .char_code(char_code), .char_valid(char_valid),
		.char_ready(char_ready), .token_kind(token_kind), .start_offset(start_offset),
		.token_length(token_length), .last_in_run(last_in_run),
		.token_valid(token_valid), .token_ready(token_ready)
	);

	c_token_lexer_checker i_checker (
		.clk(clk), .arst_n(arst_n), .char_code(char_code), .char_valid(char_valid),
		.char_ready(char_ready), .token_kind(token_kind), .start_offset(start_offset),
		.token_length(token_length), .last_in_run(last_in_run),
		.token_valid(token_valid), .token_ready(token_ready),
		.fail_count(fail_count), .pending_tokens(pending_tokens)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Half the time no gap, else mostly short gaps and now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// One byte transfer, with a random idle gap (possibly none) before it; valid stays high across back-to-back bytes
	task automatic send_byte(input logic [7:0] c);
		int g;
		g = gap_len();
		if (g > 0) begin
			char_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		char_code  <= c;
		char_valid <= 1'b1;
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Random lexeme from the source language, or noise
	function automatic string rand_lexeme();
		string ops[$] = '{"++", "--", "<=", "<<", ">=", ">>", "&&", "||", "!=", "==",
			"+", "-", "<", ">", "&", "|", "!", "=", "(", ")", "[", "]", "~", "*",
			"/", "%", "^", "?", ":", ",", "{", "}", ";", "...", ".", "..", " ", "\t"};
		string kws[$] = '{"sizeof", "typedef", "volatile", "unsigned", "int", "do",
			"registers", "x_1", "_", "Q9z", "continued"};
		string s;
		int r;
		r = $urandom_range(0, 99);
		s = "";
		if (r < 30)
			s = ops[$urandom_range(0, ops.size() - 1)];
		else if (r < 50)
			s = kws[$urandom_range(0, kws.size() - 1)];
		else if (r < 62) begin
			repeat ($urandom_range(1, 5)) s = {s, string'(8'($urandom_range(48, 57)))};
		end else if (r < 70) begin
			s = "\"";
			repeat ($urandom_range(0, 4)) s = {s, string'(8'($urandom_range(97, 122)))};
			s = {s, "\""};
		end else if (r < 80)
			s = string'(8'($urandom_range(1, 255)));
		else
			s = " ";
		return s;
	endfunction

	// Stimulus: directed texts, then random texts with end bytes
	initial begin
		int sent;
		string s;
		arst_n     = 1'b0;
		char_code  = 8'd0;
		char_valid = 1'b0;
		stim_done  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_text("int x1=volatile;");
		send_byte(CH_NUL);
		send_text("a.. ..b... \"s\"+=<<>");
		send_byte(8'hFF);
		send_byte(8'h80);
		send_text("\"ab");
		send_byte(CH_NUL);
		send_byte(CH_NUL);
		sent = 0;
		while (sent < 350) begin
			s = rand_lexeme();
			if ($urandom_range(0, 29) == 0) begin
				send_byte(CH_NUL);
				sent++;
			end
			send_text(s);
			sent += s.len();
		end
		send_byte(CH_NUL);
		char_valid <= 1'b0;
		stim_done  <= 1'b1;
	end

	// Receiver stalls
	initial begin
		int g;
		token_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g > 0) begin
				token_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			token_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Verdict once all tokens are in
	initial begin
		@(posedge clk);
		while (!(stim_done === 1'b1 && pending_tokens == 0))
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_tokens == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
